// File: hdl/ps2_mouse_packet_tracker_core_assert.svh
// assertion macros shared by the checker
`ifndef PS2_MOUSE_PACKET_TRACKER_CORE_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_CORE_ASSERT_SVH

// implication checked at every rising clock edge outside reset
`define PS2MPT_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("ps2 mouse tracker assertion failed");

// same, but also checked while reset is applied
`define PS2MPT_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error("ps2 mouse tracker assertion failed");

`endif

// File: hdl/ps2mpt_pkg.sv
package ps2mpt_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int CFG_W              = 13;
    localparam int CFG_INDEX_W        = 2;
    localparam int DELTA_W            = 10;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = CFG_W'(1280);
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = CFG_W'(720);

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = CFG_INDEX_W'(1);

    // flag byte bit positions
    localparam int FLAG_SYNC_BIT   = 3;
    localparam int FLAG_X_SIGN_BIT = 4;
    localparam int FLAG_Y_SIGN_BIT = 5;
    localparam int FLAG_X_OVF_BIT  = 6;
    localparam int FLAG_Y_OVF_BIT  = 7;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_DX   = 2'd1,
        PH_DY   = 2'd2
    } byte_phase_t;

endpackage

// File: hdl/ps2mpt_axis_update.sv
module ps2mpt_axis_update #(
    parameter int COORD_BITS = ps2mpt_pkg::COORD_BITS_DEFAULT
) (
    input  logic [COORD_BITS-1:0]                 cursor,
    input  logic signed [ps2mpt_pkg::DELTA_W-1:0] delta,
    input  logic [COORD_BITS:0]                   limit,
    output logic [COORD_BITS-1:0]                 cursor_new
);
    import ps2mpt_pkg::*;

    logic signed [COORD_BITS+1:0] delta_ext;
    logic signed [COORD_BITS+1:0] sum;
    logic signed [COORD_BITS+1:0] limit_s;
    logic [COORD_BITS:0]          limit_m1;

    assign delta_ext = (COORD_BITS+2)'(delta);
    assign sum       = signed'({2'b00, cursor}) + delta_ext;
    assign limit_s   = signed'({1'b0, limit});
    assign limit_m1  = limit - 1'b1;

    always_comb
    begin
        if (sum < 0)
        begin
            cursor_new = '0;
        end
        else if (sum >= limit_s)
        begin
            cursor_new = limit_m1[COORD_BITS-1:0];
        end
        else
        begin
            cursor_new = sum[COORD_BITS-1:0];
        end
    end

endmodule

// File: hdl/ps2_mouse_packet_tracker_core.sv
// ps2 mouse packet tracker core
// a result is registered when the third byte of a non-overflow packet is accepted
// throughput: one byte per cycle; the single output register stalls input only
// while a result waits and m_axis_tready is low
// reset (async, active low): screen 1280x720, cursor centered, framing and buttons cleared
module ps2_mouse_packet_tracker_core #(
    parameter  int COORD_BITS = ps2mpt_pkg::COORD_BITS_DEFAULT,
    localparam int OUT_W      = ((2 * COORD_BITS + 3 + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // data_byte
    input  logic                               s_axis_tuser,  // from_aux

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pos_x, pos_y, left_pressed, right_pressed, middle_pressed, zero fill
    output logic [OUT_W-1:0]                   m_axis_tdata,

    input  logic                               cfg_we,
    input  logic [ps2mpt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ps2mpt_pkg::CFG_W-1:0]       cfg_data
);
    import ps2mpt_pkg::*;

    localparam int unsigned LIMIT_CAP = 1 << COORD_BITS;

    function automatic logic [COORD_BITS:0] eff_limit(input logic [CFG_W-1:0] v);
        logic [COORD_BITS:0] r;
        if (v == '0)
        begin
            r = (COORD_BITS+1)'(1);
        end
        else if (32'(v) > 32'(LIMIT_CAP))
        begin
            r = (COORD_BITS+1)'(LIMIT_CAP);
        end
        else
        begin
            r = (COORD_BITS+1)'(v);
        end
        return r;
    endfunction

    byte_phase_t             phase_reg, phase_next;
    logic [7:0]              flag_reg, flag_next;
    logic [7:0]              dx_byte_reg, dx_byte_next;
    logic [COORD_BITS-1:0]   cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0]   cursor_y_reg, cursor_y_next;
    logic [2:0]              buttons_reg, buttons_next;
    logic [COORD_BITS:0]     limit_x_reg, limit_x_next;
    logic [COORD_BITS:0]     limit_y_reg, limit_y_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]        out_data_reg, out_data_next;

    logic                    in_xfer;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y_neg;
    logic [COORD_BITS-1:0]   x_clamped;
    logic [COORD_BITS-1:0]   y_clamped;
    logic [COORD_BITS:0]     cfg_limit;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign delta_x     = signed'({{2{flag_reg[FLAG_X_SIGN_BIT]}}, dx_byte_reg});
    assign delta_y_neg = -signed'({{2{flag_reg[FLAG_Y_SIGN_BIT]}}, s_axis_tdata});
    assign cfg_limit   = eff_limit(cfg_data);

    ps2mpt_axis_update #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .cursor     (cursor_x_reg),
        .delta      (delta_x),
        .limit      (limit_x_reg),
        .cursor_new (x_clamped)
    );

    ps2mpt_axis_update #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .cursor     (cursor_y_reg),
        .delta      (delta_y_neg),
        .limit      (limit_y_reg),
        .cursor_new (y_clamped)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        dx_byte_next   = dx_byte_reg;
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        buttons_next   = buttons_reg;
        limit_x_next   = limit_x_reg;
        limit_y_next   = limit_y_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:
                begin
                    limit_x_next  = cfg_limit;
                    cursor_x_next = cfg_limit[COORD_BITS:1];
                    cursor_y_next = limit_y_reg[COORD_BITS:1];
                end
                REG_SCREEN_HEIGHT:
                begin
                    limit_y_next  = cfg_limit;
                    cursor_x_next = limit_x_reg[COORD_BITS:1];
                    cursor_y_next = cfg_limit[COORD_BITS:1];
                end
                default:
                begin
                end
            endcase
        end

        if (in_xfer && s_axis_tuser)
        begin
            case (phase_reg)
                PH_DX:
                begin
                    dx_byte_next = s_axis_tdata;
                    phase_next   = PH_DY;
                end
                PH_DY:
                begin
                    phase_next = PH_FLAG;
                    if (!flag_reg[FLAG_X_OVF_BIT] && !flag_reg[FLAG_Y_OVF_BIT])
                    begin
                        buttons_next   = flag_reg[2:0];
                        cursor_x_next  = x_clamped;
                        cursor_y_next  = y_clamped;
                        out_valid_next = 1'b1;
                        out_data_next  = OUT_W'({flag_reg[2:0], y_clamped, x_clamped});
                    end
                end
                default:
                begin
                    phase_next = PH_FLAG;
                    if (s_axis_tdata[FLAG_SYNC_BIT])
                    begin
                        flag_next  = s_axis_tdata;
                        phase_next = PH_DX;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FLAG;
            flag_reg      <= '0;
            dx_byte_reg   <= '0;
            buttons_reg   <= '0;
            limit_x_reg   <= eff_limit(SCREEN_WIDTH_RESET);
            limit_y_reg   <= eff_limit(SCREEN_HEIGHT_RESET);
            cursor_x_reg  <= COORD_BITS'(eff_limit(SCREEN_WIDTH_RESET) >> 1);
            cursor_y_reg  <= COORD_BITS'(eff_limit(SCREEN_HEIGHT_RESET) >> 1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            dx_byte_reg   <= dx_byte_next;
            buttons_reg   <= buttons_next;
            limit_x_reg   <= limit_x_next;
            limit_y_reg   <= limit_y_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// File: hdl/ps2mpt_checker.sv
`include "ps2_mouse_packet_tracker_core_assert.svh"

module ps2mpt_checker #(
    parameter int OUT_W = 32
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // stalled result holds
    `PS2MPT_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // a new result only follows an aux byte transaction
    `PS2MPT_ASSERT(a_out_cause, clk, rst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tuser))

    // non-aux bytes never create a result
    `PS2MPT_ASSERT(a_non_aux_quiet, clk, rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tuser && (!m_axis_tvalid || m_axis_tready) |=> !m_axis_tvalid)

    // empty output register never blocks input
    `PS2MPT_ASSERT_ALWAYS(a_ready_when_empty, clk, !m_axis_tvalid |-> s_axis_tready)

endmodule

bind ps2_mouse_packet_tracker_core ps2mpt_checker #(.OUT_W(OUT_W)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: verif/ps2_mouse_report_monitor.sv
module ps2_mouse_report_monitor
    import ps2mpt_pkg::*;
#(
    parameter  int COORD_BITS = COORD_BITS_DEFAULT,
    localparam int OUT_W      = ((2 * COORD_BITS + 3 + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // data_byte
    input  logic                   s_axis_tuser,  // from_aux

    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pos_x, pos_y, left_pressed, right_pressed, middle_pressed, zero fill
    input  logic [OUT_W-1:0]       m_axis_tdata,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,

    output int                     mismatches,
    output int                     outstanding
);

    typedef struct packed {
        logic                  middle_pressed;
        logic                  right_pressed;
        logic                  left_pressed;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] pos_x;
    } cursor_report_t;

    byte_phase_t           phase;
    logic [7:0]            flag_latch;
    logic [7:0]            dx_latch;
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;
    logic [2:0]            buttons;
    logic [CFG_W-1:0]      width_reg;
    logic [CFG_W-1:0]      height_reg;
    cursor_report_t        pending_reports[$];

    function automatic int screen_limit(input logic [CFG_W-1:0] size);
        int cap;
        cap = 1 << COORD_BITS;
        if (size == '0)
            return 1;
        if (int'(size) > cap)
            return cap;
        return int'(size);
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(input int pos, input int lim);
        if (pos < 0)
            return '0;
        if (pos >= lim)
            return COORD_BITS'(lim - 1);
        return COORD_BITS'(pos);
    endfunction

    task automatic recenter();
        cur_x = COORD_BITS'(screen_limit(width_reg) / 2);
        cur_y = COORD_BITS'(screen_limit(height_reg) / 2);
    endtask

    task automatic track_byte(input logic [7:0] value);
        int             dx;
        int             dy;
        cursor_report_t rpt;
        case (phase)
            PH_DX:
            begin
                dx_latch = value;
                phase    = PH_DY;
            end
            PH_DY:
            begin
                phase = PH_FLAG;
                dx    = int'(dx_latch);
                dy    = int'(value);
                if (flag_latch[FLAG_X_SIGN_BIT])
                    dx -= 256;
                if (flag_latch[FLAG_Y_SIGN_BIT])
                    dy -= 256;
                // overflow drops the packet but keeps framing
                if (!flag_latch[FLAG_X_OVF_BIT] && !flag_latch[FLAG_Y_OVF_BIT])
                begin
                    buttons = flag_latch[2:0];
                    cur_x   = clamp_coord(int'(cur_x) + dx, screen_limit(width_reg));
                    cur_y   = clamp_coord(int'(cur_y) - dy, screen_limit(height_reg));
                    rpt.pos_x          = cur_x;
                    rpt.pos_y          = cur_y;
                    rpt.left_pressed   = buttons[0];
                    rpt.right_pressed  = buttons[1];
                    rpt.middle_pressed = buttons[2];
                    pending_reports.push_back(rpt);
                end
            end
            default:
            begin
                phase = PH_FLAG;
                if (value[FLAG_SYNC_BIT])
                begin
                    flag_latch = value;
                    phase      = PH_DX;
                end
            end
        endcase
    endtask

    task automatic log_mismatch(input string msg);
        if (mismatches < 10)
            $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cursor_report_t seen;
        cursor_report_t want;
        if (!rst_n)
        begin
            phase      = PH_FLAG;
            flag_latch = '0;
            dx_latch   = '0;
            buttons    = '0;
            width_reg  = SCREEN_WIDTH_RESET;
            height_reg = SCREEN_HEIGHT_RESET;
            recenter();
            pending_reports.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = cursor_report_t'(m_axis_tdata[$bits(cursor_report_t)-1:0]);
                if (pending_reports.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected transaction x=%0d y=%0d buttons=%b%b%b",
                        seen.pos_x, seen.pos_y, seen.middle_pressed, seen.right_pressed,
                        seen.left_pressed));
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (seen.pos_x != want.pos_x || seen.pos_y != want.pos_y
                        || seen.left_pressed != want.left_pressed
                        || seen.right_pressed != want.right_pressed
                        || seen.middle_pressed != want.middle_pressed)
                    begin
                        log_mismatch($sformatf(
                            "expected x=%0d y=%0d mrl=%b%b%b, got x=%0d y=%0d mrl=%b%b%b",
                            want.pos_x, want.pos_y, want.middle_pressed,
                            want.right_pressed, want.left_pressed,
                            seen.pos_x, seen.pos_y, seen.middle_pressed,
                            seen.right_pressed, seen.left_pressed));
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:
                    begin
                        width_reg = cfg_data;
                        recenter();
                    end
                    REG_SCREEN_HEIGHT:
                    begin
                        height_reg = cfg_data;
                        recenter();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready && s_axis_tuser)
                track_byte(s_axis_tdata);
        end
        outstanding = pending_reports.size();
    end

endmodule

// File: verif/tb_ps2_mouse_packet_tracker_core.sv
module tb_ps2_mouse_packet_tracker_core;
    import ps2mpt_pkg::*;

    localparam int COORD_BITS      = COORD_BITS_DEFAULT;
    localparam int OUT_W           = ((2 * COORD_BITS + 3 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int BYTES_PER_PHASE = 150;
    localparam int PHASE_COUNT     = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_W-1:0]       m_axis_tdata;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]       cfg_data      = '0;

    int   mismatches;
    int   outstanding;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   aux_bytes      = 0;
    int   cycles         = 0;
    logic dir_right      = 1'b1;
    logic dir_down       = 1'b0;

    ps2_mouse_packet_tracker_core #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ps2_mouse_report_monitor #(
        .COORD_BITS(COORD_BITS)
    ) u_report_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
    begin
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ps2_mouse_packet_tracker_core test failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic aux);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= aux;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        if (aux)
            aux_bytes++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        // dropped packets leave nothing to wait for, so let the output register settle before going on
        repeat (4) @(negedge clk);
    endtask

    task automatic configure_screen(input int phase_no);
        int unsigned w;
        int unsigned h;
        case (phase_no)
            0:
            begin
                w = 4096;
                h = 4096;
            end
            1:
            begin
                w = 1;
                h = 1;
            end
            2:
            begin
                w = 0;
                h = 0;
            end
            3:
            begin
                w = 8191;
                h = 4097;
            end
            4:
            begin
                w = $urandom_range(64, 1);
                h = $urandom_range(64, 1);
            end
            5:
            begin
                w = 640;
                h = 480;
            end
            6:
            begin
                w = $urandom_range(4096, 1);
                h = $urandom_range(4096, 1);
            end
            default:
            begin
                w = 16;
                h = 8191;
            end
        endcase
        // writes outside the register map must be ignored
        write_reg(phase_no % 2 ? REG_SPARE_B : REG_SPARE_A, $urandom);
        if (phase_no % 2)
        begin
            write_reg(REG_SCREEN_HEIGHT, h);
            write_reg(REG_SCREEN_WIDTH, w);
        end
        else
        begin
            write_reg(REG_SCREEN_WIDTH, w);
            write_reg(REG_SCREEN_HEIGHT, h);
        end
    endtask

    task automatic send_packet();
        logic [7:0] flags;
        logic [7:0] dx;
        logic [7:0] dy;
        flags = 8'($urandom);
        flags[FLAG_SYNC_BIT] = 1'b1;
        if ($urandom_range(99) >= 8)
        begin
            flags[FLAG_X_OVF_BIT] = 1'b0;
            flags[FLAG_Y_OVF_BIT] = 1'b0;
        end
        dx = 8'($urandom);
        dy = 8'($urandom);
        // full-scale moves toward one corner so the clamps get exercised
        if ($urandom_range(9) < 3)
        begin
            flags[FLAG_X_SIGN_BIT] = !dir_right;
            dx = dir_right ? 8'hFF : 8'h00;
            flags[FLAG_Y_SIGN_BIT] = dir_down;
            dy = dir_down ? 8'h00 : 8'hFF;
        end
        send_byte(flags, 1'b1);
        if ($urandom_range(19) == 0)
            send_byte(8'($urandom), 1'b0);
        send_byte(dx, 1'b1);
        if ($urandom_range(19) == 0)
            send_byte(8'($urandom), 1'b0);
        send_byte(dy, 1'b1);
    endtask

    initial
    begin
        int target;
        int pick;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // non-aux byte and unsynced first byte
        send_byte(8'h08, 1'b0);
        send_byte(8'h00, 1'b1);
        // plain packet, then both signs with all buttons
        send_byte(8'h08, 1'b1);
        send_byte(8'h05, 1'b1);
        send_byte(8'h03, 1'b1);
        send_byte(8'h3F, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);
        // x overflow, then y overflow with a foreign byte mid-packet
        send_byte(8'h48, 1'b1);
        send_byte(8'h10, 1'b1);
        send_byte(8'h10, 1'b1);
        send_byte(8'h88, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h10, 1'b1);
        send_byte(8'h10, 1'b1);
        // walk left into the edge
        send_byte(8'h18, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h1C, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);
        // largest positive deltas
        send_byte(8'h0F, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b1);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p / 2)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 69;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 69;
                end
                default:
                begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 28;
                end
            endcase
            configure_screen(p);
            target = aux_bytes + BYTES_PER_PHASE;
            while (aux_bytes < target)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    send_byte(8'($urandom), 1'b0);
                else if (pick < 16)
                    send_byte(8'($urandom), 1'b1);
                else
                begin
                    if ($urandom_range(11) == 0)
                    begin
                        dir_right = 1'($urandom_range(1));
                        dir_down  = 1'($urandom_range(1));
                    end
                    send_packet();
                end
            end
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("ps2_mouse_packet_tracker_core test passed");
        else
            $display("ps2_mouse_packet_tracker_core test failed");
        $finish;
    end

endmodule
